// File: sv/lbbc_pkg.sv
`default_nettype none

package lbbc_pkg;

    localparam int ENTRIES_DEF = 32;

    localparam int DEV_W  = 8;
    localparam int BLK_W  = 32;
    localparam int CNT_W  = 6;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 5;
    localparam int IDX_W  = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_GET     = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_PIN     = 2'd2,
        CMD_UNPIN   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_COUNT  = 2'd2
    } t_status;

    typedef struct packed {
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blk;
        logic [CNT_W-1:0]  cnt;
        logic [TIME_W-1:0] last;
        logic              cv;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_rd;
        logic slot_rd;
        logic eval;
        logic hit_wr;
        logic miss_wr;
        logic slot_wr;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic match;
        logic last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: sv/lru_block_buffer_cache_top.sv
// Buffer cache tag table with LRU replacement. Each item is a get, release, pin or unpin and
// yields exactly one result item. A get walks the entry table one entry per cycle through the
// single read port of the entry memory, comparing the tag and tracking the oldest unreferenced
// entry as it goes: a hit ends the walk at the matching entry, a miss walks every entry.
// Release, pin and unpin read and write one entry. A finished result sits in an output
// register, so the next item can be accepted while it waits to be taken.
`default_nettype none

module lru_block_buffer_cache_top #(
    parameter int ENTRIES = lbbc_pkg::ENTRIES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [1:0]                   i_cmd,
    input  wire logic [lbbc_pkg::DEV_W-1:0]   i_device,
    input  wire logic [lbbc_pkg::BLK_W-1:0]   i_block_number,
    input  wire logic [lbbc_pkg::SLOT_W-1:0]  i_slot,
    input  wire logic [lbbc_pkg::TIME_W-1:0]  i_now,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [lbbc_pkg::IDX_W-1:0]        o_buffer_index,
    output logic                              o_hit,
    output logic                              o_needs_read,
    output logic [1:0]                        o_status
);

    lbbc_pkg::t_dp_cmd  ctl;
    lbbc_pkg::t_dp_stat stat;

    lbbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .o_ready (o_ready),
        .o_ctl   (ctl),
        .i_stat  (stat)
    );

    lbbc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .i_device       (i_device),
        .i_block_number (i_block_number),
        .i_slot         (i_slot),
        .i_now          (i_now),
        .i_ctl          (ctl),
        .o_stat         (stat),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_buffer_index (o_buffer_index),
        .o_hit          (o_hit),
        .o_needs_read   (o_needs_read),
        .o_status       (o_status)
    );

    // one item in flight: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("item accepted while previous item still in work");

    // a disk read is only requested by a successful get
    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_needs_read) |-> (o_status == lbbc_pkg::ST_OK))
        else $error("needs_read with failing status");

    // no-free result carries zero fields
    a_nofree_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == lbbc_pkg::ST_NOFREE))
        |-> ((o_buffer_index == '0) && !o_hit && !o_needs_read))
        else $error("no-free result with nonzero fields");

    // a new result is loaded only after the previous one was taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.out_load) |-> (!o_valid || i_ready))
        else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

// File: sv/lbbc_datapath.sv
`default_nettype none

module lbbc_datapath #(
    parameter int ENTRIES = lbbc_pkg::ENTRIES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [1:0]                   i_cmd,
    input  wire logic [lbbc_pkg::DEV_W-1:0]   i_device,
    input  wire logic [lbbc_pkg::BLK_W-1:0]   i_block_number,
    input  wire logic [lbbc_pkg::SLOT_W-1:0]  i_slot,
    input  wire logic [lbbc_pkg::TIME_W-1:0]  i_now,
    input  wire lbbc_pkg::t_dp_cmd            i_ctl,
    output lbbc_pkg::t_dp_stat                o_stat,
    input  wire logic                         i_ready,
    output logic                              o_valid,
    output logic [lbbc_pkg::IDX_W-1:0]        o_buffer_index,
    output logic                              o_hit,
    output logic                              o_needs_read,
    output logic [1:0]                        o_status
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW:0]   SCAN_END = (IW+1)'(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // item registers
    lbbc_pkg::t_cmd                r_cmd;
    logic [lbbc_pkg::DEV_W-1:0]    r_dev;
    logic [lbbc_pkg::BLK_W-1:0]    r_blk;
    logic [lbbc_pkg::SLOT_W-1:0]   r_slot;
    logic [lbbc_pkg::TIME_W-1:0]   r_now;

    // entry store
    lbbc_pkg::t_entry r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_written;
    lbbc_pkg::t_entry r_rdata;
    logic               r_rd_wr;
    logic               r_rd_vld;
    logic [IW-1:0]      r_rd_idx;

    // scan state
    logic [IW:0]                   r_scan_addr;
    logic                          r_found;
    logic [IW-1:0]                 r_pick;
    logic [lbbc_pkg::TIME_W-1:0]   r_oldest;

    // pending result
    logic [lbbc_pkg::IDX_W-1:0]    r_res_idx;
    logic                          r_res_hit;
    logic                          r_res_rd;
    lbbc_pkg::t_status             r_res_st;

    logic                          r_out_vld;
    logic [lbbc_pkg::IDX_W-1:0]    r_out_idx;
    logic                          r_out_hit;
    logic                          r_out_rd;
    lbbc_pkg::t_status             r_out_st;

    lbbc_pkg::t_entry  rd_entry;
    logic              tag_eq;
    logic [31:0]       slot_ext;
    logic              slot_ok;
    logic [IW-1:0]     slot_idx;
    logic [31:0]       rd_idx_ext;
    logic [31:0]       pick_ext;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    lbbc_pkg::t_entry  wr_data;
    logic              res_ld;
    logic [lbbc_pkg::IDX_W-1:0] n_res_idx;
    logic              n_res_hit;
    logic              n_res_rd;
    lbbc_pkg::t_status n_res_st;
    logic              min_upd;

    assign rd_entry   = r_rd_wr ? r_rdata : '0;
    assign tag_eq     = (rd_entry.dev == r_dev) && (rd_entry.blk == r_blk);
    assign slot_ext   = {{(32-lbbc_pkg::SLOT_W){1'b0}}, r_slot};
    assign slot_ok    = slot_ext < 32'(ENTRIES);
    assign slot_idx   = slot_ext[IW-1:0];
    assign rd_idx_ext = 32'(r_rd_idx);
    assign pick_ext   = 32'(r_pick);

    assign o_stat.match    = r_rd_vld && tag_eq;
    assign o_stat.last     = r_rd_vld && (r_rd_idx == LAST_IDX);
    assign o_stat.out_free = !r_out_vld || i_ready;

    assign rd_en   = (i_ctl.scan_rd && (r_scan_addr < SCAN_END)) || i_ctl.slot_rd;
    assign rd_addr = i_ctl.slot_rd ? slot_idx : r_scan_addr[IW-1:0];

    // oldest unreferenced entry, lowest index wins a tie
    assign min_upd = i_ctl.eval && r_rd_vld && (rd_entry.cnt == '0)
                     && (!r_found || (rd_entry.last < r_oldest));

    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = r_rd_idx;
        wr_data   = rd_entry;
        res_ld    = 1'b0;
        n_res_idx = r_slot;
        n_res_hit = 1'b0;
        n_res_rd  = 1'b0;
        n_res_st  = lbbc_pkg::ST_OK;
        if (i_ctl.hit_wr) begin
            res_ld    = 1'b1;
            n_res_idx = rd_idx_ext[lbbc_pkg::IDX_W-1:0];
            n_res_hit = 1'b1;
            if (rd_entry.cnt == lbbc_pkg::CNT_MAX) begin
                n_res_st = lbbc_pkg::ST_COUNT;
            end else begin
                wr_en       = 1'b1;
                wr_data.cnt = rd_entry.cnt + 1'b1;
                wr_data.cv  = 1'b1;
                n_res_rd    = !rd_entry.cv;
            end
        end else if (i_ctl.miss_wr) begin
            res_ld = 1'b1;
            if (r_found) begin
                wr_en        = 1'b1;
                wr_addr      = r_pick;
                wr_data.dev  = r_dev;
                wr_data.blk  = r_blk;
                wr_data.cnt  = lbbc_pkg::CNT_W'(1);
                wr_data.last = r_now;
                wr_data.cv   = 1'b1;
                n_res_idx    = pick_ext[lbbc_pkg::IDX_W-1:0];
                n_res_rd     = 1'b1;
            end else begin
                n_res_idx = '0;
                n_res_st  = lbbc_pkg::ST_NOFREE;
            end
        end else if (i_ctl.slot_wr) begin
            res_ld = 1'b1;
            if (!slot_ok) begin
                n_res_st = lbbc_pkg::ST_COUNT;
            end else if (r_cmd == lbbc_pkg::CMD_PIN) begin
                if (rd_entry.cnt == lbbc_pkg::CNT_MAX) begin
                    n_res_st = lbbc_pkg::ST_COUNT;
                end else begin
                    wr_en       = 1'b1;
                    wr_data.cnt = rd_entry.cnt + 1'b1;
                end
            end else if (rd_entry.cnt == '0) begin
                n_res_st = lbbc_pkg::ST_COUNT;
            end else begin
                wr_en       = 1'b1;
                wr_data.cnt = rd_entry.cnt - 1'b1;
                // release of the last reference stamps the use time
                if ((r_cmd == lbbc_pkg::CMD_RELEASE)
                    && (rd_entry.cnt == lbbc_pkg::CNT_W'(1))) begin
                    wr_data.last = r_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata  <= r_mem[rd_addr];
            r_rd_wr  <= r_written[rd_addr];
            r_rd_idx <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            if (wr_en) begin
                r_written[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= lbbc_pkg::t_cmd'(i_cmd);
            r_dev  <= i_device;
            r_blk  <= i_block_number;
            r_slot <= i_slot;
            r_now  <= i_now;
        end
        if (min_upd) begin
            r_pick   <= r_rd_idx;
            r_oldest <= rd_entry.last;
        end
        if (res_ld) begin
            r_res_idx <= n_res_idx;
            r_res_hit <= n_res_hit;
            r_res_rd  <= n_res_rd;
            r_res_st  <= n_res_st;
        end
        if (i_ctl.out_load) begin
            r_out_idx <= r_res_idx;
            r_out_hit <= r_res_hit;
            r_out_rd  <= r_res_rd;
            r_out_st  <= r_res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
            r_found     <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_scan_addr <= '0;
                r_found     <= 1'b0;
            end else begin
                if (i_ctl.scan_rd && (r_scan_addr < SCAN_END)) begin
                    r_scan_addr <= r_scan_addr + 1'b1;
                end
                if (min_upd) begin
                    r_found <= 1'b1;
                end
            end
            if (i_ctl.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_vld;
    assign o_buffer_index = r_out_idx;
    assign o_hit          = r_out_hit;
    assign o_needs_read   = r_out_rd;
    assign o_status       = r_out_st;

endmodule

`default_nettype wire

// File: sv/lbbc_ctrl.sv
`default_nettype none

module lbbc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [1:0]         i_cmd,
    output logic                    o_ready,
    output lbbc_pkg::t_dp_cmd       o_ctl,
    input  wire lbbc_pkg::t_dp_stat i_stat
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_MISS = 6'b000100,
        S_SLRD = 6'b001000,
        S_SLOP = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_state = (lbbc_pkg::t_cmd'(i_cmd) == lbbc_pkg::CMD_GET) ? S_SCAN : S_SLRD;
                end
            end
            S_SCAN: begin
                // read of entry k overlaps the compare of entry k-1
                o_ctl.scan_rd = 1'b1;
                o_ctl.eval    = 1'b1;
                if (i_stat.match) begin
                    o_ctl.hit_wr = 1'b1;
                    n_state = S_OUT;
                end else if (i_stat.last) begin
                    n_state = S_MISS;
                end
            end
            S_MISS: begin
                o_ctl.miss_wr = 1'b1;
                n_state = S_OUT;
            end
            S_SLRD: begin
                o_ctl.slot_rd = 1'b1;
                n_state = S_SLOP;
            end
            S_SLOP: begin
                o_ctl.slot_wr = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: test/tb_top.sv
`default_nettype none

module tb_top;
    import lbbc_pkg::*;

    localparam int N_ENTRIES = ENTRIES_DEF;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic             hit;
        logic             rd;
        t_status          st;
    } buf_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_cmd = CMD_GET;
    logic [DEV_W-1:0]   i_device = '0;
    logic [BLK_W-1:0]   i_block_number = '0;
    logic [SLOT_W-1:0]  i_slot = '0;
    logic [TIME_W-1:0]  i_now = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [IDX_W-1:0]   o_buffer_index;
    logic               o_hit;
    logic               o_needs_read;
    logic [1:0]         o_status;

    // shadow copy of the entry table
    t_entry             shadow_tab [N_ENTRIES];
    buf_result_t        pending_results [$];
    buf_result_t        last_pred;
    buf_result_t        got_want;
    logic [TIME_W-1:0]  tick = '0;
    bit                 steady = 1'b0;
    int                 mismatches = 0;
    int                 n_sent = 0;
    int                 n_hits = 0;
    int                 n_misses = 0;
    int                 n_nofree = 0;
    int                 n_count_err = 0;

    lru_block_buffer_cache_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_device       (i_device),
        .i_block_number (i_block_number),
        .i_slot         (i_slot),
        .i_now          (i_now),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_buffer_index (o_buffer_index),
        .o_hit          (o_hit),
        .o_needs_read   (o_needs_read),
        .o_status       (o_status)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // applies one request to the shadow table and returns its result
    function automatic buf_result_t cache_apply(t_cmd c, logic [DEV_W-1:0] dev,
                                                logic [BLK_W-1:0] blk,
                                                logic [SLOT_W-1:0] slot,
                                                logic [TIME_W-1:0] now);
        buf_result_t       r;
        int                match_at;
        int                pick;
        logic [TIME_W-1:0] oldest;
        logic [CNT_W-1:0]  cnt;
        r.idx = '0;
        r.hit = 1'b0;
        r.rd  = 1'b0;
        r.st  = ST_OK;
        match_at = -1;
        pick = -1;
        oldest = '0;
        if (c == CMD_GET) begin
            for (int i = 0; i < N_ENTRIES; i++) begin
                if (match_at < 0 && shadow_tab[i].dev == dev && shadow_tab[i].blk == blk)
                    match_at = i;
            end
            if (match_at >= 0) begin
                r.idx = match_at[IDX_W-1:0];
                r.hit = 1'b1;
                if (shadow_tab[match_at].cnt == CNT_MAX) begin
                    r.st = ST_COUNT;
                end else begin
                    r.rd = ~shadow_tab[match_at].cv;
                    shadow_tab[match_at].cnt = shadow_tab[match_at].cnt + 1'b1;
                    shadow_tab[match_at].cv = 1'b1;
                end
                return r;
            end
            // oldest unreferenced entry, lowest index wins a tie
            for (int i = 0; i < N_ENTRIES; i++) begin
                if (shadow_tab[i].cnt == '0 && (pick < 0 || shadow_tab[i].last < oldest)) begin
                    pick = i;
                    oldest = shadow_tab[i].last;
                end
            end
            if (pick < 0) begin
                r.st = ST_NOFREE;
                return r;
            end
            shadow_tab[pick].dev  = dev;
            shadow_tab[pick].blk  = blk;
            shadow_tab[pick].cnt  = CNT_W'(1);
            shadow_tab[pick].last = now;
            shadow_tab[pick].cv   = 1'b1;
            r.idx = pick[IDX_W-1:0];
            r.rd  = 1'b1;
            return r;
        end
        r.idx = slot[IDX_W-1:0];
        cnt = shadow_tab[slot].cnt;
        if (c == CMD_PIN) begin
            if (cnt == CNT_MAX)
                r.st = ST_COUNT;
            else
                shadow_tab[slot].cnt = cnt + 1'b1;
        end else if (cnt == '0) begin
            r.st = ST_COUNT;
        end else begin
            shadow_tab[slot].cnt = cnt - 1'b1;
            if (c == CMD_RELEASE && cnt == 1)
                shadow_tab[slot].last = now;
        end
        return r;
    endfunction

    // mostly back to back, sometimes a short gap, rarely a long one
    function automatic int pick_gap();
        int p;
        if (steady)
            return 0;
        p = $urandom_range(99);
        if (p < 50)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin : ready_driver
        int run;
        forever begin
            @(posedge i_clk);
            run = pick_gap();
            i_ready <= (run == 0);
            repeat (run) @(posedge i_clk);
        end
    end

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result item, expected none, got index %0d status %0d",
                         $time, o_buffer_index, o_status);
            end else begin
                got_want = pending_results.pop_front();
                check_field("buffer_index", 32'(got_want.idx), 32'(o_buffer_index));
                check_field("hit", 32'(got_want.hit), 32'(o_hit));
                check_field("needs_read", 32'(got_want.rd), 32'(o_needs_read));
                check_field("status", 32'(got_want.st), 32'(o_status));
            end
        end
    end

    task automatic send_req(input t_cmd c, input logic [DEV_W-1:0] dev,
                            input logic [BLK_W-1:0] blk, input logic [SLOT_W-1:0] slot,
                            input logic [TIME_W-1:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= c;
        i_device       <= dev;
        i_block_number <= blk;
        i_slot         <= slot;
        i_now          <= now;
        do @(posedge i_clk); while (!o_ready);
        last_pred = cache_apply(c, dev, blk, slot, now);
        pending_results.push_back(last_pred);
        n_sent++;
        if (last_pred.st == ST_NOFREE)
            n_nofree++;
        else if (last_pred.st == ST_COUNT)
            n_count_err++;
        else if (c == CMD_GET && last_pred.hit)
            n_hits++;
        else if (c == CMD_GET)
            n_misses++;
    endtask

    // sender holds off until every result has been taken
    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // every entry starts tagged device 0 block 0 with stale contents
    task automatic test_reset_tags();
        send_req(CMD_GET, 8'd0, 32'd0, 5'd0, 32'd5);
        send_req(CMD_GET, 8'd0, 32'd0, 5'd0, 32'd6);
        send_req(CMD_RELEASE, 8'd0, 32'd0, 5'd0, 32'd7);
        send_req(CMD_RELEASE, 8'd0, 32'd0, 5'd0, 32'd8);
        send_req(CMD_RELEASE, 8'd0, 32'd0, 5'd0, 32'd9);
        send_req(CMD_UNPIN, 8'd0, 32'd0, 5'd1, 32'd10);
        wait_drain();
    endtask

    task automatic test_field_extremes();
        logic [IDX_W-1:0] idx;
        send_req(CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF);
        idx = last_pred.idx;
        send_req(CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'd0);
        send_req(CMD_PIN, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
        send_req(CMD_UNPIN, 8'd0, 32'd0, 5'd31, 32'd0);
        send_req(CMD_UNPIN, 8'd0, 32'd0, 5'd31, 32'd0);
        send_req(CMD_RELEASE, 8'd0, 32'd0, 5'd31, 32'd0);
        send_req(CMD_RELEASE, 8'd0, 32'd0, idx, 32'hFFFF_FFFF);
        send_req(CMD_RELEASE, 8'd0, 32'd0, idx, 32'd0);
        // entry with stamp zero is older than the max stamp
        send_req(CMD_GET, 8'h01, 32'h8000_0000, 5'd0, 32'd11);
        send_req(CMD_RELEASE, 8'd0, 32'd0, last_pred.idx, 32'd12);
        wait_drain();
    endtask

    task automatic test_count_saturate();
        logic [IDX_W-1:0] idx;
        steady = 1'b1;
        send_req(CMD_GET, 8'h5A, 32'h0000_BEEF, 5'd0, 32'd20);
        idx = last_pred.idx;
        repeat (62) send_req(CMD_PIN, 8'd0, 32'd0, idx, 32'd21);
        steady = 1'b0;
        send_req(CMD_PIN, 8'd0, 32'd0, idx, 32'd22);
        send_req(CMD_GET, 8'h5A, 32'h0000_BEEF, 5'd0, 32'd23);
        steady = 1'b1;
        repeat (62) send_req(CMD_UNPIN, 8'd0, 32'd0, idx, 32'd24);
        steady = 1'b0;
        send_req(CMD_RELEASE, 8'd0, 32'd0, idx, 32'd25);
        send_req(CMD_RELEASE, 8'd0, 32'd0, idx, 32'd26);
        send_req(CMD_GET, 8'h5A, 32'h0000_BEEF, 5'd0, 32'd27);
        send_req(CMD_RELEASE, 8'd0, 32'd0, last_pred.idx, 32'd28);
        wait_drain();
    endtask

    // fill every entry, overflow with one more miss, then free with tied stamps
    task automatic test_no_free();
        for (int k = 0; k <= N_ENTRIES; k++)
            send_req(CMD_GET, 8'h40 + k[7:0], 32'hA000_0000 + k, 5'd0, 32'd100 + k);
        send_req(CMD_GET, 8'h40, 32'hA000_0000, 5'd0, 32'd200);
        send_req(CMD_UNPIN, 8'd0, 32'd0, last_pred.idx, 32'd201);
        for (int s = 0; s < N_ENTRIES; s++)
            send_req(CMD_RELEASE, 8'd0, 32'd0, s[SLOT_W-1:0], 32'd500 + (s % 8));
        send_req(CMD_GET, 8'h77, 32'h0000_0077, 5'd0, 32'd600);
        send_req(CMD_GET, 8'h78, 32'h0000_0078, 5'd0, 32'd601);
        wait_drain();
        tick = 32'd1000;
    endtask

    task automatic test_random_mix(input int n_items);
        t_cmd              c;
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blk;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] now;
        int                sel;
        int                live [$];
        for (int k = 0; k < n_items; k++) begin
            if (k % 100 == 99)
                wait_drain();
            steady = ((k / 50) % 4 == 3);
            sel = $urandom_range(99);
            tick = tick + $urandom_range(3);
            now = ($urandom_range(9) == 0) ? $urandom : tick;
            dev = DEV_W'($urandom);
            blk = $urandom;
            slot = SLOT_W'($urandom_range(31));
            if (sel < 40) begin
                c = CMD_GET;
                // a small tag pool keeps hits frequent
                if ($urandom_range(9) < 7) begin
                    dev = DEV_W'($urandom_range(3));
                    blk = $urandom_range(15);
                end
            end else begin
                if (sel < 70)
                    c = CMD_RELEASE;
                else if (sel < 82)
                    c = CMD_PIN;
                else
                    c = CMD_UNPIN;
                live.delete();
                for (int i = 0; i < N_ENTRIES; i++)
                    if (shadow_tab[i].cnt != '0)
                        live.push_back(i);
                if (live.size() > 0 && $urandom_range(99) < 85)
                    slot = SLOT_W'(live[$urandom_range(live.size() - 1)]);
            end
            send_req(c, dev, blk, slot, now);
        end
        steady = 1'b0;
        wait_drain();
    endtask

    initial begin
        for (int i = 0; i < N_ENTRIES; i++)
            shadow_tab[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_tags();
        test_field_extremes();
        test_count_saturate();
        test_no_free();
        test_random_mix(184);
        repeat (80) @(posedge i_clk);
        $display("ran %0d requests: %0d get hits, %0d get misses, %0d no-free, %0d count errors",
                 n_sent, n_hits, n_misses, n_nofree, n_count_err);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
